/* rtl/tms_pkg.sv */
// Package for the 16-bit eight-register instruction step block.
// Holds command codes, opcodes, function codes and controller command/status types.
// No dependencies.
`default_nettype none
package tms_pkg;
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_SETPC = 2'd2;
  localparam logic [1:0] CMD_STEP  = 2'd3;

  localparam logic [3:0] OP_RTYPE = 4'h0;
  localparam logic [3:0] OP_BEQ   = 4'h1;
  localparam logic [3:0] OP_JUMP  = 4'h3;
  localparam logic [3:0] OP_LW    = 4'h4;
  localparam logic [3:0] OP_SW    = 4'h5;
  localparam logic [3:0] OP_ADDI  = 4'hA;
  localparam logic [3:0] OP_SUBI  = 4'hB;
  localparam logic [3:0] OP_HALT  = 4'hF;

  localparam logic [2:0] FN_AND = 3'd0;
  localparam logic [2:0] FN_OR  = 3'd1;
  localparam logic [2:0] FN_ADD = 3'd2;
  localparam logic [2:0] FN_SUB = 3'd3;
  localparam logic [2:0] FN_MUL = 3'd4;
  localparam logic [2:0] FN_DIV = 3'd5;

  // memory address source
  localparam logic [1:0] AS_REQ  = 2'd0;
  localparam logic [1:0] AS_PC   = 2'd1;
  localparam logic [1:0] AS_EA   = 2'd2;

  typedef struct packed {
    logic       clear;      // clear result fields
    logic       mem_we;
    logic [1:0] addr_sel;
    logic       addr_hi;    // 0 = first byte, 1 = second byte
    logic       wr_from_req;// write data from request, else rt
    logic       cap_hi;     // capture read byte as high byte
    logic       cap_lo;
    logic       to_ir;      // capture target: ir else read_data
    logic       decode;     // latch operands and ea
    logic       div_start;
    logic       mul_done;   // take product
    logic       finish;     // commit step
    logic       set_pc;
  } ctl_t;

  typedef struct packed {
    logic [3:0] op;
    logic       halt;
    logic       div_busy;
    logic       is_div;
    logic       is_mul;
  } sts_t;
endpackage
`default_nettype wire

/* rtl/tiny_mips16_instruction_step.sv */
// Top level of the 16-bit eight-register instruction step block.
// Depends on tms_pkg, tms_ctrl, tms_datapath (which uses tms_ram, tms_div).
//
// Usage: one request on the input channel (in_valid/in_stall) carries a
// command, an address and write data. Commands write a big-endian memory
// word, read one, set the start pc (clearing halt), or step one instruction.
// Every request gives exactly one result on the output channel
// (out_valid/out_stall), held in output registers until taken.
// A step while halted skips the fetch and executes nothing; a divide
// waits for the 16-step divider.
// One request is in flight at a time; the next is taken once the
// previous result has been moved to the output registers and, if it is
// still waiting there, once it is no longer stalled.
// Reset clears registers, pc, halt flag and the handshake; memory contents
// are undefined until written. A stalled result holds its value.
`default_nettype none
module tiny_mips16_instruction_step #(
  parameter int MEM_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [15:0] address,
  input  wire logic [15:0] write_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      read_data,
  output logic [15:0]      executed_pc,
  output logic             reg_written,
  output logic [2:0]       reg_index,
  output logic [15:0]      reg_value,
  output logic             halted,
  output logic             div_by_zero
);
  tms_pkg::ctl_t ctl;
  tms_pkg::sts_t sts;
  logic [15:0] addr_q, wdata_q;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      addr_q  <= address;
      wdata_q <= write_data;
    end
  end

  tms_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .out_valid(out_valid), .out_stall(out_stall),
    .ctl(ctl), .sts(sts)
  );

  tms_datapath #(.MEM_BYTES(MEM_BYTES)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .req_address(ctl.clear ? address : addr_q),
    .req_write_data(ctl.clear ? write_data : wdata_q),
    .read_data(read_data), .executed_pc(executed_pc),
    .reg_written(reg_written), .reg_index(reg_index), .reg_value(reg_value),
    .halted(halted), .div_by_zero(div_by_zero)
  );
endmodule
`default_nettype wire

/* rtl/tms_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module tms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* rtl/tms_div.sv */
// Iterative 16-bit unsigned restoring divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module tms_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             busy,
  output logic [15:0]      quotient
);
  logic [16:0] rem;
  logic [15:0] dvs;
  logic [4:0]  count;
  logic [16:0] trial;
  logic [16:0] shifted;
  assign shifted = {rem[15:0], quotient[15]};
  assign trial = shifted - {1'b0, dvs};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 5'd16;
    end else if (busy) begin
      count <= count - 5'd1;
      if (count == 5'd1) busy <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      if (!trial[16]) begin
        rem      <= trial;
        quotient <= {quotient[14:0], 1'b1};
      end else begin
        rem      <= shifted;
        quotient <= {quotient[14:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/tms_datapath.sv */
// Datapath: byte memory, register file, pc, halt flag, ALU and result registers.
// Depends on tms_pkg, tms_ram, tms_div.
`default_nettype none
module tms_datapath #(
  parameter int MEM_BYTES = 65536
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tms_pkg::ctl_t     ctl,
  output tms_pkg::sts_t          sts,
  input  wire logic [15:0]       req_address,
  input  wire logic [15:0]       req_write_data,
  output logic [15:0]            read_data,
  output logic [15:0]            executed_pc,
  output logic                   reg_written,
  output logic [2:0]             reg_index,
  output logic [15:0]            reg_value,
  output logic                   halted,
  output logic                   div_by_zero
);
  localparam int AW = $clog2(MEM_BYTES);

  logic [15:0] regs [8];
  logic [15:0] pc;
  logic [15:0] ir;
  logic [15:0] a, b, ea;
  logic [15:0] prod;
  logic [15:0] base, byte_addr;
  logic [7:0]  mem_wdata, mem_rdata;
  logic [15:0] wsrc;
  logic        div_busy;
  logic [15:0] quotient;

  logic [3:0] op;
  logic [2:0] rs, rt, rd, fn;
  logic [15:0] imm;
  assign op  = ir[15:12];
  assign rs  = ir[11:9];
  assign rt  = ir[8:6];
  assign rd  = ir[5:3];
  assign fn  = ir[2:0];
  assign imm = {10'd0, ir[5:0]};

  always_comb begin
    case (ctl.addr_sel)
      tms_pkg::AS_PC: base = pc;
      tms_pkg::AS_EA: base = ea;
      default:        base = req_address;
    endcase
    byte_addr = base + {15'd0, ctl.addr_hi};
    wsrc      = ctl.wr_from_req ? req_write_data : b;
    mem_wdata = ctl.addr_hi ? wsrc[7:0] : wsrc[15:8];
  end

  tms_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(ctl.mem_we), .addr(byte_addr[AW-1:0]),
    .wdata(mem_wdata), .rdata(mem_rdata)
  );

  tms_div u_div (
    .clk(clk), .rst(rst), .start(ctl.div_start),
    .dividend(a), .divisor(b), .busy(div_busy), .quotient(quotient)
  );

  assign sts.op       = op;
  assign sts.halt     = halted;
  assign sts.div_busy = div_busy;
  assign sts.is_div   = (op == tms_pkg::OP_RTYPE) && (fn == tms_pkg::FN_DIV) && (b != 16'd0);
  assign sts.is_mul   = (op == tms_pkg::OP_RTYPE) && (fn == tms_pkg::FN_MUL);

  logic [15:0] npc;
  assign npc = pc + 16'd2;

  logic        commit_wr, commit_dz, commit_halt;
  logic [2:0]  commit_idx;
  logic [15:0] commit_val, commit_pc;

  always_comb begin
    commit_wr   = 1'b0;
    commit_idx  = '0;
    commit_val  = '0;
    commit_dz   = 1'b0;
    commit_halt = halted;
    commit_pc   = npc;
    unique case (op)
      tms_pkg::OP_RTYPE: begin
        case (fn)
          tms_pkg::FN_AND: begin commit_wr = 1'b1; commit_val = a & b; end
          tms_pkg::FN_OR:  begin commit_wr = 1'b1; commit_val = a | b; end
          tms_pkg::FN_ADD: begin commit_wr = 1'b1; commit_val = a + b; end
          tms_pkg::FN_SUB: begin commit_wr = 1'b1; commit_val = a - b; end
          tms_pkg::FN_MUL: begin commit_wr = 1'b1; commit_val = prod; end
          tms_pkg::FN_DIV: begin
            if (b == 16'd0) commit_dz = 1'b1;
            else begin
              commit_wr  = 1'b1;
              commit_val = quotient;
            end
          end
          default: ;
        endcase
        if (commit_wr) commit_idx = rd;
      end
      tms_pkg::OP_ADDI: begin
        commit_wr = 1'b1; commit_idx = rt; commit_val = a + imm;
      end
      tms_pkg::OP_SUBI: begin
        commit_wr = 1'b1; commit_idx = rt; commit_val = a - imm;
      end
      tms_pkg::OP_LW: begin
        commit_wr = 1'b1; commit_idx = rt; commit_val = {read_data[15:8], mem_rdata};
      end
      tms_pkg::OP_BEQ: begin
        if (a == b) commit_pc = npc + {imm[14:0], 1'b0};
      end
      tms_pkg::OP_JUMP: commit_pc = npc + {{3{ir[11]}}, ir[11:0], 1'b0};
      tms_pkg::OP_HALT: commit_halt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_hi && ctl.to_ir) ir[15:8] <= mem_rdata;
    if (ctl.cap_lo && ctl.to_ir) ir[7:0] <= mem_rdata;
    if (ctl.decode) begin
      a  <= regs[rs];
      b  <= regs[rt];
      ea <= regs[rs] + {imm[14:0], 1'b0};
    end
    if (ctl.mul_done) prod <= a * b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_data   <= '0;
      executed_pc <= '0;
      reg_written <= 1'b0;
      reg_index   <= '0;
      reg_value   <= '0;
      div_by_zero <= 1'b0;
      pc          <= '0;
      halted      <= 1'b0;
      for (int i = 0; i < 8; i++) regs[i] <= '0;
    end else if (ctl.clear) begin
      read_data   <= '0;
      executed_pc <= '0;
      reg_written <= 1'b0;
      reg_index   <= '0;
      reg_value   <= '0;
      div_by_zero <= 1'b0;
      if (ctl.set_pc) begin
        pc     <= req_address;
        halted <= 1'b0;
      end
    end else if (ctl.cap_hi && !ctl.to_ir) begin
      read_data[15:8] <= mem_rdata;
    end else if (ctl.cap_lo && !ctl.to_ir) begin
      read_data[7:0] <= mem_rdata;
    end else if (ctl.finish) begin
      read_data   <= '0;
      executed_pc <= pc;
      pc          <= commit_pc;
      reg_written <= commit_wr;
      reg_index   <= commit_idx;
      reg_value   <= commit_val;
      div_by_zero <= commit_dz;
      halted      <= commit_halt;
      if (commit_wr) regs[commit_idx] <= commit_val;
    end
  end
endmodule
`default_nettype wire

/* rtl/tms_ctrl.sv */
// Controller state machine: sequences memory byte accesses, divide and commit.
// Depends on tms_pkg.
`default_nettype none
module tms_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    command,
  output logic               out_valid,
  input  wire logic          out_stall,
  output tms_pkg::ctl_t      ctl,
  input  wire tms_pkg::sts_t sts
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_W1   = 4'd1;
  localparam logic [3:0] S_R0   = 4'd2;
  localparam logic [3:0] S_R1   = 4'd3;
  localparam logic [3:0] S_R2   = 4'd4;
  localparam logic [3:0] S_F0   = 4'd5;
  localparam logic [3:0] S_F1   = 4'd6;
  localparam logic [3:0] S_F2   = 4'd7;
  localparam logic [3:0] S_DEC  = 4'd8;
  localparam logic [3:0] S_EXE  = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_M0   = 4'd11;
  localparam logic [3:0] S_M1   = 4'd12;
  localparam logic [3:0] S_M2   = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  logic [3:0] state, state_next;
  logic       out_valid_next;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    ctl = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          ctl.clear = 1'b1;
          unique case (command)
            tms_pkg::CMD_WRITE: begin
              ctl.mem_we = 1'b1; ctl.wr_from_req = 1'b1;
              state_next = S_W1;
            end
            tms_pkg::CMD_READ: state_next = S_R0;
            tms_pkg::CMD_SETPC: begin
              ctl.set_pc = 1'b1; state_next = S_OUT;
            end
            default: state_next = S_F0;
          endcase
        end
      end
      S_W1: begin
        ctl.mem_we = 1'b1; ctl.wr_from_req = 1'b1; ctl.addr_hi = 1'b1;
        state_next = S_OUT;
      end
      S_R0: state_next = S_R1;
      S_R1: begin ctl.addr_hi = 1'b1; ctl.cap_hi = 1'b1; state_next = S_R2; end
      S_R2: begin ctl.cap_lo = 1'b1; state_next = S_OUT; end
      S_F0: begin
        if (sts.halt) state_next = S_OUT;
        else begin ctl.addr_sel = tms_pkg::AS_PC; state_next = S_F1; end
      end
      S_F1: begin
        ctl.addr_sel = tms_pkg::AS_PC; ctl.addr_hi = 1'b1;
        ctl.cap_hi = 1'b1; ctl.to_ir = 1'b1; state_next = S_F2;
      end
      S_F2: begin ctl.cap_lo = 1'b1; ctl.to_ir = 1'b1; state_next = S_DEC; end
      S_DEC: begin ctl.decode = 1'b1; state_next = S_EXE; end
      S_EXE: begin
        if (sts.is_div) begin ctl.div_start = 1'b1; state_next = S_DIV; end
        else if (sts.is_mul) begin ctl.mul_done = 1'b1; state_next = S_FIN; end
        else if (sts.op == tms_pkg::OP_LW) begin
          ctl.addr_sel = tms_pkg::AS_EA; state_next = S_M1;
        end else if (sts.op == tms_pkg::OP_SW) begin
          ctl.addr_sel = tms_pkg::AS_EA; ctl.mem_we = 1'b1; state_next = S_M0;
        end else state_next = S_FIN;
      end
      S_DIV: if (!sts.div_busy) state_next = S_FIN;
      S_M0: begin
        ctl.addr_sel = tms_pkg::AS_EA; ctl.addr_hi = 1'b1; ctl.mem_we = 1'b1;
        state_next = S_FIN;
      end
      S_M1: begin
        ctl.addr_sel = tms_pkg::AS_EA; ctl.addr_hi = 1'b1; ctl.cap_hi = 1'b1;
        state_next = S_M2;
      end
      S_M2: begin ctl.finish = 1'b1; state_next = S_OUT; end
      S_FIN: begin ctl.finish = 1'b1; state_next = S_OUT; end
      S_OUT: begin out_valid_next = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire
